### sv/nsm_pkg.sv
package nsm_pkg;

    // Pattern storage is fixed by the two 32-bit pattern words.
    localparam int PATTERN_BYTES   = 8;
    localparam int PAT_IDX_W       = $clog2(PATTERN_BYTES);
    localparam int MAX_PATTERN_DEF = 8;

    localparam int LEN_W  = 4;
    localparam int WORD_W = 32;
    localparam int CNT_W  = 16;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_LENGTH = 2'd0,
        REG_PATTERN_LOW    = 2'd1,
        REG_PATTERN_HIGH   = 2'd2
    } cfg_reg_t;

    typedef logic [PATTERN_BYTES-1:0][7:0] pat_bytes_t;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic             match_found;
        logic [CNT_W-1:0] byte_position;
        logic [CNT_W-1:0] match_total;
        logic             text_done;
    } out_item_t;

    // Per-item control shared by the window and the counters.
    typedef struct packed {
        logic take;
        logic last;
    } step_t;

endpackage

### sv/nsm_window.sv
module nsm_window #(
    parameter int MAX_PATTERN = nsm_pkg::MAX_PATTERN_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  nsm_pkg::step_t          step,
    input  logic [7:0]              text_byte,
    input  logic [nsm_pkg::LEN_W-1:0] len,
    input  nsm_pkg::pat_bytes_t     pattern,
    output logic                    match
);

    localparam int CW = $clog2(MAX_PATTERN + 1);

    logic [7:0]          recent_reg  [MAX_PATTERN];
    logic [7:0]          recent_next [MAX_PATTERN];
    logic [7:0]          win         [MAX_PATTERN];
    logic [CW-1:0]       since_reg;
    logic [CW-1:0]       since_next;
    logic [CW-1:0]       since_inc;
    logic [MAX_PATTERN-1:0] miss;
    logic                armed;

    // Window as it stands with the new byte shifted in, newest first.
    always_comb
    begin
        win[0] = text_byte;
        for (int k = 1; k < MAX_PATTERN; k++)
        begin
            win[k] = recent_reg[k-1];
        end
    end

    assign since_inc = (since_reg < CW'(MAX_PATTERN)) ? since_reg + CW'(1) : since_reg;
    assign armed     = nsm_pkg::LEN_W'(since_inc) >= len;

    // Compare window slot k against pattern byte len-1-k, slots past len ignored.
    always_comb
    begin
        logic [nsm_pkg::LEN_W-1:0] idx;
        idx = '0;
        for (int k = 0; k < MAX_PATTERN; k++)
        begin
            idx     = len - nsm_pkg::LEN_W'(k) - nsm_pkg::LEN_W'(1);
            miss[k] = (nsm_pkg::LEN_W'(k) < len) &&
                      (win[k] != pattern[idx[nsm_pkg::PAT_IDX_W-1:0]]);
        end
    end

    assign match = armed && (miss == '0);

    always_comb
    begin
        for (int k = 0; k < MAX_PATTERN; k++)
        begin
            recent_next[k] = step.last ? 8'd0 : win[k];
        end
        if (step.last || match)
        begin
            since_next = '0;
        end
        else
        begin
            since_next = since_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_PATTERN; k++)
            begin
                recent_reg[k] <= 8'd0;
            end
            since_reg <= '0;
        end
        else if (step.take)
        begin
            recent_reg <= recent_next;
            since_reg  <= since_next;
        end
    end

endmodule

### sv/nsm_count.sv
module nsm_count (
    input  logic                      clk,
    input  logic                      rst_n,
    input  nsm_pkg::step_t            step,
    input  logic                      match,
    output logic [nsm_pkg::CNT_W-1:0] position,
    output logic [nsm_pkg::CNT_W-1:0] total
);

    localparam logic [nsm_pkg::CNT_W-1:0] SAT = '1;

    logic [nsm_pkg::CNT_W-1:0] pos_reg;
    logic [nsm_pkg::CNT_W-1:0] pos_next;
    logic [nsm_pkg::CNT_W-1:0] mcnt_reg;
    logic [nsm_pkg::CNT_W-1:0] mcnt_next;

    assign position = pos_reg;
    assign total    = (match && mcnt_reg != SAT) ? mcnt_reg + nsm_pkg::CNT_W'(1) : mcnt_reg;

    // Saturate both counts; drop them at the end of a text.
    always_comb
    begin
        if (step.last)
        begin
            pos_next  = '0;
            mcnt_next = '0;
        end
        else
        begin
            pos_next  = (pos_reg != SAT) ? pos_reg + nsm_pkg::CNT_W'(1) : pos_reg;
            mcnt_next = total;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            mcnt_reg <= '0;
        end
        else if (step.take)
        begin
            pos_reg  <= pos_next;
            mcnt_reg <= mcnt_next;
        end
    end

endmodule

### sv/nonoverlap_substring_matcher.sv
// An accepted item's result is registered and appears on out_item in the next cycle.
// Throughput: one item per cycle while results are taken; the window compare and counter
// update finish in the accepting cycle, and the result register frees as it is taken.
// Reset (rst_n, async, active low): window, restart count and counters clear,
// pattern_length reads 1, both pattern words read zero, no result pending.
module nonoverlap_substring_matcher #(
    parameter int MAX_PATTERN = nsm_pkg::MAX_PATTERN_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // text channel
    input  logic                          in_valid,
    output logic                          in_ready,
    input  nsm_pkg::in_item_t             in_item,
    // result channel
    output logic                          out_valid,
    input  logic                          out_ready,
    output nsm_pkg::out_item_t            out_item,
    // configuration writes
    input  logic                          cfg_write,
    input  logic [nsm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [nsm_pkg::WORD_W-1:0]    cfg_data
);

    logic [nsm_pkg::LEN_W-1:0]  len_cfg_reg;
    logic [nsm_pkg::WORD_W-1:0] pat_low_reg;
    logic [nsm_pkg::WORD_W-1:0] pat_high_reg;

    logic [nsm_pkg::LEN_W-1:0]  len_used;
    nsm_pkg::pat_bytes_t        pattern;

    nsm_pkg::step_t             step;
    logic                       match;
    logic [nsm_pkg::CNT_W-1:0]  position;
    logic [nsm_pkg::CNT_W-1:0]  total;

    logic                       out_valid_reg;
    logic                       out_valid_next;
    nsm_pkg::out_item_t         out_item_reg;
    nsm_pkg::out_item_t         out_item_next;

    // Configuration: writes land directly, unknown indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_cfg_reg  <= nsm_pkg::LEN_W'(1);
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (nsm_pkg::cfg_reg_t'(cfg_index))
                nsm_pkg::REG_PATTERN_LENGTH: len_cfg_reg  <= cfg_data[nsm_pkg::LEN_W-1:0];
                nsm_pkg::REG_PATTERN_LOW:    pat_low_reg  <= cfg_data;
                nsm_pkg::REG_PATTERN_HIGH:   pat_high_reg <= cfg_data;
                default:                     ;
            endcase
        end
    end

    // Clamp the length to 1..MAX_PATTERN.
    always_comb
    begin
        if (len_cfg_reg == '0)
        begin
            len_used = nsm_pkg::LEN_W'(1);
        end
        else if (len_cfg_reg > nsm_pkg::LEN_W'(MAX_PATTERN))
        begin
            len_used = nsm_pkg::LEN_W'(MAX_PATTERN);
        end
        else
        begin
            len_used = len_cfg_reg;
        end
    end

    // Byte 0 of the pattern sits in bits 7:0 of the low word.
    assign pattern = {pat_high_reg, pat_low_reg};

    // Take a new item whenever the result register is empty or draining.
    assign in_ready  = !out_valid_reg || out_ready;
    assign step.take = in_valid && in_ready;
    assign step.last = in_item.last_byte;

    nsm_window #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .text_byte (in_item.text_byte),
        .len       (len_used),
        .pattern   (pattern),
        .match     (match)
    );

    nsm_count u_count (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .match    (match),
        .position (position),
        .total    (total)
    );

    // Result register: load on accept, hold while the consumer stalls.
    always_comb
    begin
        out_item_next.match_found   = match;
        out_item_next.byte_position = position;
        out_item_next.match_total   = total;
        out_item_next.text_done     = in_item.last_byte;

        if (step.take)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step.take)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

### verif/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import nsm_pkg::*;

    // Register index past the last register; writes to it must leave the pattern alone.
    localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;

    // Cycles the result side refuses results while the text side keeps offering bytes.
    localparam int HOLD_CYCLES = 60;
    localparam int RANDOM_SETTINGS = 8;
    localparam int BYTES_PER_SETTING = 56;

    typedef struct {
        bit                   is_write;
        logic [CFG_IDX_W-1:0] reg_index;
        logic [WORD_W-1:0]    value;
        in_item_t             text;
        bit                   pinned;
        out_item_t            want;
    } step_row_t;

    // One entry per offered byte: a typed-in result, or none (use the predictor).
    typedef struct {
        bit        pinned;
        out_item_t value;
    } typed_result_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    in_item_t             in_item   = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    out_item_t            out_item;
    logic                 cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [WORD_W-1:0]    cfg_data  = '0;

    // Idle percentage shared by both sides; zero during the no-idle stretch.
    int unsigned idle_pct = 11;
    bit          hold_req = 1'b0;

    int unsigned err_count       = 0;
    int unsigned bytes_taken     = 0;
    int unsigned reports_checked = 0;
    int unsigned hits_seen       = 0;
    int unsigned stall_cycles    = 0;

    // Predictor copy of the block: pattern registers and per-text search state.
    logic [LEN_W-1:0]  pat_len       = 4'd1;
    logic [WORD_W-1:0] pat_lo        = '0;
    logic [WORD_W-1:0] pat_hi        = '0;
    pat_bytes_t        window        = '0;
    int unsigned       since_restart = 0;
    logic [CNT_W-1:0]  pos_cnt       = '0;
    logic [CNT_W-1:0]  hit_cnt       = '0;

    out_item_t     pending_reports[$];
    typed_result_t typed_q[$];

    nonoverlap_substring_matcher dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    // Zero length acts as one byte, anything past the window as the full window.
    function automatic int unsigned used_len(input logic [LEN_W-1:0] len);
        if (len == 0)
            return 1;
        if (len > PATTERN_BYTES)
            return PATTERN_BYTES;
        return len;
    endfunction

    // Advance the search by one text byte and return the result it produces.
    function automatic out_item_t scan_text_byte(input in_item_t item);
        int unsigned len;
        int unsigned k;
        pat_bytes_t  pat;
        logic        hit;
        out_item_t   res;
        len = used_len(pat_len);
        pat = {pat_hi, pat_lo};
        // Shift the newest byte into slot 0.
        window = {window[PATTERN_BYTES-2:0], item.text_byte};
        if (since_restart < PATTERN_BYTES)
            since_restart++;
        // Compare only once enough bytes follow the last match (non-overlap rule).
        hit = (since_restart >= len);
        for (k = 0; k < len; k++)
            if (window[k] != pat[len-1-k])
                hit = 1'b0;
        if (hit)
        begin
            since_restart = 0;
            if (hit_cnt != '1)
                hit_cnt++;
        end
        res.match_found   = hit;
        res.byte_position = pos_cnt;
        res.match_total   = hit_cnt;
        res.text_done     = item.last_byte;
        if (pos_cnt != '1)
            pos_cnt++;
        // Clear the per-text state after the final byte of a text.
        if (item.last_byte)
        begin
            window        = '0;
            since_restart = 0;
            pos_cnt       = '0;
            hit_cnt       = '0;
        end
        return res;
    endfunction

    task automatic check_report(input out_item_t got, input out_item_t want);
        if (got.match_found !== want.match_found)
        begin
            err_count++;
            $error("match_found: expected %0d, actual %0d", want.match_found, got.match_found);
        end
        if (got.byte_position !== want.byte_position)
        begin
            err_count++;
            $error("byte_position: expected %0d, actual %0d",
                   want.byte_position, got.byte_position);
        end
        if (got.match_total !== want.match_total)
        begin
            err_count++;
            $error("match_total: expected %0d, actual %0d", want.match_total, got.match_total);
        end
        if (got.text_done !== want.text_done)
        begin
            err_count++;
            $error("text_done: expected %0d, actual %0d", want.text_done, got.text_done);
        end
        reports_checked++;
        if (got.match_found === 1'b1)
            hits_seen++;
    endtask

    // Everything is sampled at the rising edge, so all values seen are pre-edge values.
    always @(posedge clk)
    begin : scoreboard
        out_item_t     want;
        typed_result_t typed;
        if (rst_n)
        begin
            if (in_valid && !in_ready)
                stall_cycles++;
            // Retire the oldest expectation against each taken result.
            if (out_valid && out_ready)
            begin
                if (pending_reports.size() == 0)
                begin
                    err_count++;
                    $error("result with no expectation waiting: position %0d",
                           out_item.byte_position);
                end
                else
                begin
                    want = pending_reports.pop_front();
                    check_report(out_item, want);
                end
            end
            // Predict on every accepted byte; a typed-in row overrides the prediction
            // but the predictor state still advances.
            if (in_valid && in_ready)
            begin
                typed = typed_q.pop_front();
                want  = scan_text_byte(in_item);
                if (typed.pinned)
                    want = typed.value;
                pending_reports.push_back(want);
                bytes_taken++;
            end
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_PATTERN_LENGTH: pat_len = cfg_data[LEN_W-1:0];
                    REG_PATTERN_LOW:    pat_lo  = cfg_data;
                    REG_PATTERN_HIGH:   pat_hi  = cfg_data;
                    default:            ;
                endcase
            end
        end
    end

    // Result side: take results at random, or hold off entirely on request.
    initial
    begin : result_sink
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                // Refuse results long enough for the block to fill and stall its input.
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            out_ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    // Offer one text byte and hold it until accepted. Valid is left high on return,
    // so the next byte can follow back to back.
    task automatic send_text_byte(input in_item_t item, input bit pinned, input out_item_t want);
        typed_result_t typed;
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        typed.pinned = pinned;
        typed.value  = want;
        typed_q.push_back(typed);
        in_valid <= 1'b1;
        in_item  <= item;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Drop valid and wait until every expected result has come back.
    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_reports.size() != 0);
    endtask

    // Leave the write enable high; the caller drops it after the last write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    task automatic program_pattern(input logic [LEN_W-1:0] len, input logic [WORD_W-1:0] lo,
                                   input logic [WORD_W-1:0] hi);
        write_reg(REG_PATTERN_LENGTH, WORD_W'(len));
        write_reg(REG_PATTERN_LOW, lo);
        write_reg(REG_PATTERN_HIGH, hi);
        cfg_write <= 1'b0;
    endtask

    function automatic step_row_t wr(input logic [CFG_IDX_W-1:0] idx,
                                     input logic [WORD_W-1:0] value);
        step_row_t row;
        row           = '{default: '0};
        row.is_write  = 1'b1;
        row.reg_index = idx;
        row.value     = value;
        return row;
    endfunction

    function automatic step_row_t tx(input logic [7:0] b, input logic l);
        step_row_t row;
        row      = '{default: '0};
        row.text = '{text_byte: b, last_byte: l};
        return row;
    endfunction

    function automatic step_row_t tx_pinned(input logic [7:0] b, input logic l, input logic hit,
                                            input int unsigned pos, input int unsigned total);
        step_row_t row;
        row        = tx(b, l);
        row.pinned = 1'b1;
        row.want   = '{match_found: hit, byte_position: CNT_W'(pos),
                       match_total: CNT_W'(total), text_done: l};
        return row;
    endfunction

    initial
    begin : stimulus
        step_row_t            script[$];
        bit                   prev_write;
        logic [LEN_W-1:0]     len_sel;
        logic [7:0]           alpha[2];
        pat_bytes_t           pat;
        logic [7:0]           queued_bytes[$];
        logic [7:0]           b;
        logic                 l;
        int unsigned          r;
        int unsigned          n;
        int                   s;
        int                   sent;

        script = '{
            // Reset pattern is one zero byte.
            tx_pinned(8'h00, 1'b0, 1'b1, 0, 1),
            tx_pinned(8'hFF, 1'b0, 1'b0, 1, 1),
            tx_pinned(8'h00, 1'b1, 1'b1, 2, 2),
            // Zero length acts as one byte.
            wr(REG_PATTERN_LENGTH, 32'd0),
            wr(REG_PATTERN_LOW, 32'h0000_00FF),
            tx_pinned(8'hFF, 1'b0, 1'b1, 0, 1),
            // Length past the window clamps to the full eight bytes; text continues.
            wr(REG_PATTERN_LENGTH, 32'd15),
            wr(REG_PATTERN_LOW, 32'h4433_2211),
            wr(REG_PATTERN_HIGH, 32'h8877_6655),
            tx(8'h11, 1'b0), tx(8'h22, 1'b0), tx(8'h33, 1'b0), tx(8'h44, 1'b0),
            tx(8'h55, 1'b0), tx(8'h66, 1'b0), tx(8'h77, 1'b0), tx(8'h88, 1'b1),
            // Overlapping candidates: "aaa" in seven a's matches only twice.
            wr(REG_PATTERN_LENGTH, 32'd3),
            wr(REG_PATTERN_LOW, 32'h0061_6161),
            wr(REG_NONE, 32'hFFFF_FFFF),
            tx(8'h61, 1'b0), tx(8'h61, 1'b0), tx(8'h61, 1'b0), tx(8'h61, 1'b0),
            tx(8'h61, 1'b0), tx(8'h61, 1'b0), tx(8'h61, 1'b1),
            // Pattern change mid-text keeps the window.
            tx(8'h61, 1'b0),
            wr(REG_PATTERN_LENGTH, 32'd2),
            wr(REG_PATTERN_LOW, 32'h0000_6261),
            tx(8'h62, 1'b0),
            tx(8'hFF, 1'b1)
        };

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: writes only once the block has gone quiet.
        prev_write = 1'b0;
        foreach (script[k])
        begin
            if (script[k].is_write)
            begin
                if (!prev_write)
                    drain_results();
                write_reg(script[k].reg_index, script[k].value);
            end
            else
            begin
                if (prev_write)
                    cfg_write <= 1'b0;
                send_text_byte(script[k].text, script[k].pinned, script[k].want);
            end
            prev_write = script[k].is_write;
        end
        drain_results();

        // Random settings; texts mostly built from pattern copies over a two-byte alphabet
        // so that partial and overlapping occurrences are common.
        for (s = 0; s < RANDOM_SETTINGS; s++)
        begin
            case (s)
                0:       len_sel = 4'd1;
                1:       len_sel = 4'd8;
                2:       len_sel = 4'd0;
                3:       len_sel = 4'd15;
                default: len_sel = LEN_W'($urandom_range(15));
            endcase
            alpha[0] = 8'($urandom_range(255));
            alpha[1] = 8'($urandom_range(255));
            for (n = 0; n < PATTERN_BYTES; n++)
                pat[n] = alpha[$urandom_range(1)];
            if (s == 6)
                pat = {$urandom(), $urandom()};
            program_pattern(len_sel, pat[3:0], pat[7:4]);

            idle_pct = (s == 5) ? 0 : 11;
            if (s == 3)
                hold_req = 1'b1;

            // Leftover bytes are discarded; the text itself carries on across the change.
            queued_bytes.delete();
            for (sent = 0; sent < BYTES_PER_SETTING; sent++)
            begin
                if (queued_bytes.size() == 0)
                begin
                    r = $urandom_range(99);
                    if (r < 45)
                    begin
                        for (n = 0; n < used_len(len_sel); n++)
                            queued_bytes.push_back(pat[n]);
                    end
                    else if (r < 80)
                        queued_bytes.push_back(alpha[$urandom_range(1)]);
                    else
                        queued_bytes.push_back(8'($urandom_range(255)));
                end
                b = queued_bytes.pop_front();
                l = ($urandom_range(15) == 0);
                send_text_byte('{text_byte: b, last_byte: l}, 1'b0, '0);
            end
            drain_results();
        end
        idle_pct = 11;

        // Let a stray extra result show up before closing.
        repeat (4) @(posedge clk);

        $display("Sent %0d text bytes, checked %0d results with %0d matches;",
                 bytes_taken, reports_checked, hits_seen);
        $display("input stalled %0d cycles; covered lengths 0 to 15, mid-text pattern changes,",
                 stall_cycles);
        $display("an ignored register index and a long result-side stall.");
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin : watchdog
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
